>>> src/ebvc_pkg.sv
`default_nettype none
package ebvc_pkg;

  // Item kind carried on in_tuser
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  // Register addresses on the byte bus
  localparam logic [7:0] REG_STATUS = 8'h01;
  localparam logic [7:0] REG_CMD    = 8'h02;
  localparam logic [7:0] REG_MOVE   = 8'h03;
  localparam logic [7:0] REG_TARGET = 8'h04;

  localparam logic [7:0] STATUS_BASE = 8'h80;
  localparam logic [7:0] CMD_RESET   = 8'h80;

  // Command byte bits
  localparam int CMD_LOAD_BIT   = 4;
  localparam int CMD_REBASE_BIT = 5;
  localparam int CMD_OPEN_BIT   = 6;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  typedef struct packed {
    logic [7:0] status_now;
    logic       valve_open;
    logic [7:0] read_byte;
  } out_item_t;

  localparam int OUT_ITEM_W = $bits(out_item_t);

endpackage
`default_nettype wire

>>> src/encoder_batch_valve_controller_top.sv
`default_nettype none
// Channel | Dir | tdata (low bit up)                                   | tuser
// in_     | in  | bus_byte[7:0], encoder_count[39:8], start_press[40], | action[1:0]
//         |     | stop_press[41], zero[47:42]                          |
// out_    | out | read_byte[7:0], valve_open[8], status_now[16:9],     | -
//         |     | zero[23:17]                                          |
//
// One item per cycle while in_tready is high: each item is resolved in one pass of
// combinational logic (one COUNT_WIDTH subtract, a sign test and 32-bit target
// compares) from the state registers.
// A two-entry output (register plus skid) lets an input transfer proceed while one
// result waits; in_tready drops only when both entries hold results.
// rst_n is synchronous, active low; it restores all controller state.
module encoder_batch_valve_controller_top #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // bus_byte[7:0], encoder_count[39:8], start_press[40], stop_press[41]
  input  wire logic [ebvc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // action[1:0]
  input  wire logic [1:0]                         in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // read_byte[7:0], valve_open[8], status_now[16:9]
  output logic [ebvc_pkg::OUT_TDATA_W-1:0]        out_tdata
);
  import ebvc_pkg::*;

  // Input fields
  action_t                 action;
  logic [7:0]              bus_byte;
  logic [31:0]             encoder_count;
  logic                    start_press;
  logic                    stop_press;

  assign action        = action_t'(in_tuser);
  assign bus_byte      = in_tdata[7:0];
  assign encoder_count = in_tdata[39:8];
  assign start_press   = in_tdata[40];
  assign stop_press    = in_tdata[41];

  // Controller state
  logic                    addr_seen_r,  addr_seen_nxt;
  logic [7:0]              reg_addr_r,   reg_addr_nxt;
  logic                    stat_armed_r, stat_armed_nxt;
  logic                    move_armed_r, move_armed_nxt;
  logic [7:0]              cmd_r,        cmd_nxt;
  logic                    cmd_pend_r,   cmd_pend_nxt;
  logic [1:0]              idx_r,        idx_nxt;
  logic [7:0]              tgt_bytes_r  [4];
  logic [7:0]              tgt_bytes_nxt[4];
  logic [7:0]              move_bytes_r  [4];
  logic [7:0]              move_bytes_nxt[4];
  logic [31:0]             tgt_val_r,    tgt_val_nxt;
  logic [COUNT_WIDTH-1:0]  base_r,       base_nxt;
  logic [7:0]              status_r,     status_nxt;
  logic                    started_r,    started_nxt;
  logic                    stopped_r,    stopped_nxt;
  logic                    valve_r,      valve_nxt;

  // Output buffering
  logic                    out_valid_r,  out_valid_nxt;
  out_item_t               out_item_r,   out_item_nxt;
  logic                    skid_valid_r, skid_valid_nxt;
  out_item_t               skid_item_r,  skid_item_nxt;

  logic                    in_acc;
  logic                    out_take;
  logic [7:0]              rd_byte;
  logic [COUNT_WIDTH-1:0]  count;
  logic signed [COUNT_WIDTH-1:0] mv;
  logic signed [COUNT_WIDTH-1:0] mv_eff;
  logic [31:0]             mv32;
  logic                    positive;
  out_item_t               new_item;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_take  = out_valid_r && out_tready;

  assign count    = encoder_count[COUNT_WIDTH-1:0];
  assign mv       = signed'(count - base_r);
  assign positive = (mv > 0);
  assign mv32     = 32'(mv);

  always_comb begin
    addr_seen_nxt  = addr_seen_r;
    reg_addr_nxt   = reg_addr_r;
    stat_armed_nxt = stat_armed_r;
    move_armed_nxt = move_armed_r;
    cmd_nxt        = cmd_r;
    cmd_pend_nxt   = cmd_pend_r;
    idx_nxt        = idx_r;
    tgt_bytes_nxt  = tgt_bytes_r;
    move_bytes_nxt = move_bytes_r;
    tgt_val_nxt    = tgt_val_r;
    base_nxt       = base_r;
    status_nxt     = status_r;
    started_nxt    = started_r;
    stopped_nxt    = stopped_r;
    valve_nxt      = valve_r;
    mv_eff         = mv;
    rd_byte        = 8'h00;

    unique case (action)
      ACT_WRITE: begin
        if (!addr_seen_r) begin
          reg_addr_nxt  = bus_byte;
          addr_seen_nxt = 1'b1;
          if (bus_byte == REG_STATUS) begin
            stat_armed_nxt = 1'b1;
          end else if (bus_byte == REG_MOVE) begin
            move_armed_nxt = 1'b1;
          end
        end else if (reg_addr_r == REG_CMD) begin
          cmd_nxt      = bus_byte;
          cmd_pend_nxt = 1'b1;
        end else if (reg_addr_r == REG_TARGET) begin
          tgt_bytes_nxt[idx_r] = bus_byte;
          idx_nxt              = idx_r + 2'd1;
        end
      end
      ACT_READ: begin
        if (stat_armed_r) begin
          rd_byte        = status_r;
          stat_armed_nxt = 1'b0;
        end else if (move_armed_r) begin
          rd_byte = move_bytes_r[idx_r];
          // last byte ends the movement read
          if (idx_r == 2'd3) begin
            move_armed_nxt = 1'b0;
          end
          idx_nxt = idx_r + 2'd1;
        end
      end
      ACT_STOP: begin
        addr_seen_nxt = 1'b0;
        idx_nxt       = 2'd0;
      end
      ACT_TICK: begin
        status_nxt = STATUS_BASE | {1'b0, valve_r, positive, started_r, stopped_r, 3'b000};
        if (positive) begin
          move_bytes_nxt[0] = mv32[31:24];
          move_bytes_nxt[1] = mv32[23:16];
          move_bytes_nxt[2] = mv32[15:8];
          move_bytes_nxt[3] = mv32[7:0];
        end
        if (cmd_pend_r) begin
          if (cmd_r[CMD_LOAD_BIT]) begin
            tgt_val_nxt = {tgt_bytes_r[0], tgt_bytes_r[1], tgt_bytes_r[2], tgt_bytes_r[3]};
          end
          if (cmd_r[CMD_REBASE_BIT]) begin
            base_nxt = count;
            mv_eff   = '0;
          end
          valve_nxt    = cmd_r[CMD_OPEN_BIT];
          started_nxt  = cmd_r[CMD_OPEN_BIT];
          stopped_nxt  = !cmd_r[CMD_OPEN_BIT];
          cmd_pend_nxt = 1'b0;
        end
        if (start_press) begin
          base_nxt    = count;
          mv_eff      = '0;
          valve_nxt   = 1'b1;
          started_nxt = 1'b1;
          stopped_nxt = 1'b0;
        end
        if (stop_press) begin
          valve_nxt   = 1'b0;
          started_nxt = 1'b0;
          stopped_nxt = 1'b1;
        end
        // auto-close once a started batch reaches its target
        if (started_nxt && (tgt_val_nxt != 32'd0) && (32'(mv_eff) >= tgt_val_nxt)) begin
          valve_nxt   = 1'b0;
          started_nxt = 1'b0;
          stopped_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign new_item = '{status_now: status_nxt, valve_open: valve_nxt, read_byte: rd_byte};

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    skid_valid_nxt = skid_valid_r;
    skid_item_nxt  = skid_item_r;
    if (!out_valid_r || out_take) begin
      // advance skid entry first, else take the new transfer directly
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_acc;
        if (in_acc) begin
          out_item_nxt = new_item;
        end
      end
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
      skid_item_nxt  = new_item;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_ITEM_W)'(0), out_item_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_seen_r  <= 1'b0;
      reg_addr_r   <= 8'h00;
      stat_armed_r <= 1'b0;
      move_armed_r <= 1'b0;
      cmd_r        <= CMD_RESET;
      cmd_pend_r   <= 1'b0;
      idx_r        <= 2'd0;
      for (int i = 0; i < 4; i++) begin
        tgt_bytes_r[i]  <= 8'h00;
        move_bytes_r[i] <= 8'h00;
      end
      tgt_val_r    <= 32'd0;
      base_r       <= '0;
      status_r     <= STATUS_BASE;
      started_r    <= 1'b0;
      stopped_r    <= 1'b0;
      valve_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        addr_seen_r  <= addr_seen_nxt;
        reg_addr_r   <= reg_addr_nxt;
        stat_armed_r <= stat_armed_nxt;
        move_armed_r <= move_armed_nxt;
        cmd_r        <= cmd_nxt;
        cmd_pend_r   <= cmd_pend_nxt;
        idx_r        <= idx_nxt;
        tgt_bytes_r  <= tgt_bytes_nxt;
        move_bytes_r <= move_bytes_nxt;
        tgt_val_r    <= tgt_val_nxt;
        base_r       <= base_nxt;
        status_r     <= status_nxt;
        started_r    <= started_nxt;
        stopped_r    <= stopped_nxt;
        valve_r      <= valve_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while output register is empty");

  a_valve_run: assert property (@(posedge clk) disable iff (!rst_n)
    valve_r |-> (started_r && !stopped_r))
    else $error("valve open without a started batch");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (action != ACT_READ)) |-> (rd_byte == 8'h00))
    else $error("nonzero read byte on a non-read item");

  a_status_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.status_now[7] && (out_item_r.status_now[2:0] == 3'b000)))
    else $error("malformed status byte on output");

  a_move_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (action == ACT_READ) && !stat_armed_r && move_armed_r && (idx_r == 2'd3))
      |=> (!move_armed_r && (idx_r == 2'd0)))
    else $error("movement read did not close after its last byte");

endmodule
`default_nettype wire
